[rtl/assert_macros.svh]
// assertion helpers for the detector rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

[rtl/sord_pkg.sv]
`default_nettype none

package sord_pkg;

  // block constants
  localparam int RUN_LENGTH  = 5;
  localparam int SCAN_POINTS = 360;
  localparam int SECTORS     = 4;

  // field widths
  localparam int RANGE_W = 16;
  localparam int IDX_W   = 9;
  localparam int SPAN_W  = 18;
  localparam int LIMIT_W = 16;
  localparam int CFG_W   = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W   = 3;

  // sector numbering
  localparam int S_FRONT_STOP = 0;
  localparam int S_REAR_STOP  = 1;
  localparam int S_FRONT_SLOW = 2;
  localparam int S_REAR_SLOW  = 3;

  // queue between classifier and run tracker
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register reset values
  localparam logic [SECTORS-1:0][SPAN_W-1:0] SPAN_RESET = {
    18'd82119, 18'd174099, 18'd77009, 18'd163879
  };
  localparam logic [SECTORS-1:0][LIMIT_W-1:0] LIMIT_RESET = {
    16'd400, 16'd400, 16'd200, 16'd150
  };

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRONT_STOP_SPAN  = 3'd0,
    CFG_REAR_STOP_SPAN   = 3'd1,
    CFG_FRONT_SLOW_SPAN  = 3'd2,
    CFG_REAR_SLOW_SPAN   = 3'd3,
    CFG_FRONT_STOP_LIMIT = 3'd4,
    CFG_REAR_STOP_LIMIT  = 3'd5,
    CFG_FRONT_SLOW_LIMIT = 3'd6,
    CFG_REAR_SLOW_LIMIT  = 3'd7
  } cfg_idx_t;

  // input beat
  typedef struct packed {
    logic [RANGE_W-1:0] sample_range;
    logic [IDX_W-1:0]   sample_index;
    logic               scan_end;
  } in_t;

  // result beat
  typedef struct packed {
    logic front_stop_clear;
    logic rear_stop_clear;
    logic front_slow_clear;
    logic rear_slow_clear;
  } out_t;

  // classified sample as queued
  typedef struct packed {
    logic [SECTORS-1:0] hit;
    logic [SECTORS-1:0] wrap;
    logic               last;
  } cls_t;

  // queue head as seen by the run tracker
  typedef struct packed {
    logic valid;
    cls_t beat;
  } head_t;

endpackage

`default_nettype wire

[rtl/sord_front.sv]
`default_nettype none

module sord_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [sord_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sord_pkg::CFG_W-1:0]    cfg_data,
  input  wire sord_pkg::in_t                 sample,
  output sord_pkg::cls_t                     cls
);
  import sord_pkg::*;

  logic [SECTORS-1:0][SPAN_W-1:0]  span;
  logic [SECTORS-1:0][LIMIT_W-1:0] limit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      span  <= SPAN_RESET;
      limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRONT_STOP_SPAN:  span[S_FRONT_STOP]  <= cfg_data;
        CFG_REAR_STOP_SPAN:   span[S_REAR_STOP]   <= cfg_data;
        CFG_FRONT_SLOW_SPAN:  span[S_FRONT_SLOW]  <= cfg_data;
        CFG_REAR_SLOW_SPAN:   span[S_REAR_SLOW]   <= cfg_data;
        CFG_FRONT_STOP_LIMIT: limit[S_FRONT_STOP] <= cfg_data[LIMIT_W-1:0];
        CFG_REAR_STOP_LIMIT:  limit[S_REAR_STOP]  <= cfg_data[LIMIT_W-1:0];
        CFG_FRONT_SLOW_LIMIT: limit[S_FRONT_SLOW] <= cfg_data[LIMIT_W-1:0];
        CFG_REAR_SLOW_LIMIT:  limit[S_REAR_SLOW]  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // per sector membership and threshold compare
  always_comb begin
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic             member;
    cls.last = sample.scan_end;
    for (int k = 0; k < SECTORS; k++) begin
      lo = span[k][SPAN_W-1:IDX_W];
      hi = span[k][IDX_W-1:0];
      if (sample.sample_index >= SCAN_POINTS) begin
        member = 1'b0;
      end else if (lo < hi) begin
        member = (sample.sample_index >= lo) && (sample.sample_index < hi);
      end else if (lo > hi) begin
        member = (sample.sample_index >= lo) || (sample.sample_index < hi);
      end else begin
        member = 1'b0;
      end
      cls.hit[k]  = member && (sample.sample_range <= limit[k]);
      cls.wrap[k] = lo > hi;
    end
  end

endmodule

`default_nettype wire

[rtl/sord_queue.sv]
`default_nettype none

module sord_queue (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire sord_pkg::cls_t             push_data,
  input  wire logic                       pop,
  output logic                            full,
  output logic [sord_pkg::QCNT_W-1:0]     count,
  output sord_pkg::head_t                 head
);
  import sord_pkg::*;

  cls_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.beat  = entry[rd_ptr];

  // pointer wrap at queue depth
  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sord_back.sv]
`default_nettype none

module sord_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sord_pkg::head_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output sord_pkg::out_t       out_data
);
  import sord_pkg::*;

  logic [SECTORS-1:0][CNT_W-1:0] run_count;
  logic [SECTORS-1:0][CNT_W-1:0] head_run_count;
  logic [SECTORS-1:0]            head_run_open;
  logic [SECTORS-1:0]            run_found;

  logic [SECTORS-1:0][CNT_W-1:0] run_count_next;
  logic [SECTORS-1:0][CNT_W-1:0] head_run_count_next;
  logic [SECTORS-1:0]            head_run_open_next;
  logic [SECTORS-1:0]            run_found_next;
  logic [SECTORS-1:0]            clear;

  // a closing beat waits while the result register is still held
  assign pop = head.valid && (!head.beat.last || !out_valid || out_ready);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v >= CNT_W'(RUN_LENGTH)) ? CNT_W'(RUN_LENGTH) : v + 1'b1;
  endfunction

  // run counter update and end of scan verdict
  always_comb begin
    logic [CNT_W:0] joined;
    for (int k = 0; k < SECTORS; k++) begin
      run_count_next[k]      = run_count[k];
      head_run_count_next[k] = head_run_count[k];
      head_run_open_next[k]  = head_run_open[k];
      run_found_next[k]      = run_found[k];
      if (head.beat.hit[k]) begin
        run_count_next[k] = sat_inc(run_count[k]);
        if (head_run_open[k]) begin
          head_run_count_next[k] = sat_inc(head_run_count[k]);
        end
        if (run_count_next[k] >= CNT_W'(RUN_LENGTH)) begin
          run_found_next[k] = 1'b1;
        end
      end else begin
        run_count_next[k]     = '0;
        head_run_open_next[k] = 1'b0;
      end
      joined   = {1'b0, run_count_next[k]} + {1'b0, head_run_count_next[k]};
      clear[k] = !(run_found_next[k] ||
                   (head.beat.wrap[k] && joined >= (CNT_W+1)'(RUN_LENGTH)));
    end
  end

  // run state, cleared after each scan
  always_ff @(posedge clk) begin
    if (rst || (pop && head.beat.last)) begin
      run_count      <= '0;
      head_run_count <= '0;
      head_run_open  <= '1;
      run_found      <= '0;
    end else if (pop) begin
      run_count      <= run_count_next;
      head_run_count <= head_run_count_next;
      head_run_open  <= head_run_open_next;
      run_found      <= run_found_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.beat.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.beat.last) begin
      out_data.front_stop_clear <= clear[S_FRONT_STOP];
      out_data.rear_stop_clear  <= clear[S_REAR_STOP];
      out_data.front_slow_clear <= clear[S_FRONT_SLOW];
      out_data.rear_slow_clear  <= clear[S_REAR_SLOW];
    end
  end

endmodule

`default_nettype wire

[rtl/sector_obstacle_run_detector.sv]
`default_nettype none

// Sector obstacle run detector. Range samples of a scan stream in one beat
// per cycle; each beat is checked against four sectors (front stop, rear
// stop, front slow, rear slow) on acceptance, queued in a two-entry queue,
// and folded into per-sector run counters one beat per cycle. The beat that
// carries scan_end yields one result beat with four clear flags through the
// queue and the result register (out_valid is set as the counters take
// it). The rate of one sample per cycle is set by the counter update, which
// takes one queued beat each cycle; a pending result that is not taken holds
// back only the next closing beat, and inputs keep flowing until the queue
// fills. Configuration writes through cfg_we/cfg_index/cfg_data take effect
// at the next clock edge and belong to idle periods between scans.
`include "assert_macros.svh"

module sector_obstacle_run_detector (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire sord_pkg::in_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output sord_pkg::out_t                      out_data,
  input  wire logic                           cfg_we,
  input  wire logic [sord_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sord_pkg::CFG_W-1:0]     cfg_data
);
  import sord_pkg::*;

  cls_t              cls;
  head_t             head;
  logic              push;
  logic              pop;
  logic              q_full;
  logic [QCNT_W-1:0] q_count;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // classifier and configuration
  sord_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (in_data),
    .cls       (cls)
  );

  // decoupling queue
  sord_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cls),
    .pop       (pop),
    .full      (q_full),
    .count     (q_count),
    .head      (head)
  );

  // run tracker and result register
  sord_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // checks
  `ASSERT_NEVER(a_q_overfill, q_count > QCNT_W'(QUEUE_DEPTH), "queue count above depth")
  `ASSERT_NEVER(a_pop_empty, pop && !head.valid, "pop from empty queue")
  `ASSERT_CLK(a_no_overwrite, (pop && head.beat.last) |-> (!out_valid || out_ready), "result overwritten")
  `ASSERT_CLK(a_result_src, $rose(out_valid) |-> $past(pop && head.beat.last), "result without scan end")

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import sord_pkg::*;

  localparam int ITEM_GOAL     = 1600;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // shadow registers and per-sector run tracking
  logic [SPAN_W-1:0]  span_q [SECTORS];
  logic [LIMIT_W-1:0] limit_q [SECTORS];
  logic [CNT_W-1:0]   run_len [SECTORS];
  logic [CNT_W-1:0]   head_len [SECTORS];
  logic               head_open [SECTORS];
  logic               seen_run [SECTORS];

  in_t  pending_samples [$];
  out_t expected_flags [$];

  bit idle_on = 1'b0;
  int hold_asked = 0;
  int hold_granted = 0;
  int send_gap = 0;
  int stall_left = 0;
  int samples_queued = 0;
  int samples_taken = 0;
  int results_seen = 0;
  int settings_loaded = 0;
  int failures = 0;
  int cycle_count = 0;

  sector_obstacle_run_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic bit covers(logic [SPAN_W-1:0] span, logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    lo = span[SPAN_W-1:IDX_W];
    hi = span[IDX_W-1:0];
    if (idx >= SCAN_POINTS) return 1'b0;
    if (lo < hi) return (idx >= lo) && (idx < hi);
    if (lo > hi) return (idx >= lo) || (idx < hi);
    return 1'b0;
  endfunction

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
    return (v >= RUN_LENGTH) ? CNT_W'(RUN_LENGTH) : v + 1'b1;
  endfunction

  task automatic clear_tracks();
    for (int k = 0; k < SECTORS; k++) begin
      run_len[k] = '0;
      head_len[k] = '0;
      head_open[k] = 1'b1;
      seen_run[k] = 1'b0;
    end
  endtask

  // fold one accepted sample into the runs; a closing sample yields the flags
  task automatic fold_sample(input in_t s);
    logic [SECTORS-1:0] blocked;
    out_t flags;
    for (int k = 0; k < SECTORS; k++) begin
      if (covers(span_q[k], s.sample_index) && s.sample_range <= limit_q[k]) begin
        run_len[k] = bump(run_len[k]);
        if (head_open[k]) head_len[k] = bump(head_len[k]);
        if (run_len[k] >= RUN_LENGTH) seen_run[k] = 1'b1;
      end else begin
        run_len[k] = '0;
        head_open[k] = 1'b0;
      end
    end
    if (s.scan_end) begin
      for (int k = 0; k < SECTORS; k++) begin
        // wrapping sector: tail run joins the head run
        blocked[k] = seen_run[k] ||
          ((span_q[k][SPAN_W-1:IDX_W] > span_q[k][IDX_W-1:0]) &&
           (int'(run_len[k]) + int'(head_len[k]) >= RUN_LENGTH));
      end
      flags.front_stop_clear = !blocked[S_FRONT_STOP];
      flags.rear_stop_clear  = !blocked[S_REAR_STOP];
      flags.front_slow_clear = !blocked[S_FRONT_SLOW];
      flags.rear_slow_clear  = !blocked[S_REAR_SLOW];
      expected_flags.insert(expected_flags.size(), flags);
      clear_tracks();
    end
  endtask

  // ---------------------------------------------------------------- random picks

  function automatic int idle_len();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // range near the limit of some sector, biased to hit or miss
  function automatic int pick_range(bit hot);
    int k;
    int r;
    k = $urandom_range(0, SECTORS - 1);
    r = $urandom_range(0, 99);
    if (r < 4) return 65535;
    if (r < 8) return $urandom_range(0, 65535);
    if (hot) begin
      if (r < 30) return limit_q[k];
      return $urandom_range(0, limit_q[k]);
    end
    if (r < 40 && limit_q[k] != 16'hFFFF) return limit_q[k] + 1;
    if (r < 75) return $urandom_range(limit_q[k], 65535);
    return 65535;
  endfunction

  function automatic logic [SPAN_W-1:0] pick_span();
    int lo;
    int hi;
    int r;
    lo = $urandom_range(0, SCAN_POINTS - 1);
    r = $urandom_range(0, 9);
    if (r == 0) hi = lo;
    else if (r < 3) hi = (lo + $urandom_range(1, 4)) % SCAN_POINTS;
    else if (r < 7) hi = (lo + $urandom_range(5, 60)) % SCAN_POINTS;
    else if (r < 9) hi = $urandom_range(0, 511);
    else begin
      // wraps past the last index
      lo = $urandom_range(320, SCAN_POINTS - 1);
      hi = $urandom_range(0, 40);
    end
    if (lo * 512 + hi > 184167) hi = SCAN_POINTS - 1;
    return SPAN_W'(lo * 512 + hi);
  endfunction

  function automatic int pick_limit();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 65535;
    if (r < 4) return $urandom_range(0, 65535);
    return $urandom_range(50, 1000);
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  task automatic add_sample(input int rng, input int idx, input bit last);
    in_t s;
    s.sample_range = RANGE_W'(rng);
    s.sample_index = IDX_W'(idx);
    s.scan_end = last;
    pending_samples.insert(pending_samples.size(), s);
    samples_queued++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    if (idx <= CFG_REAR_SLOW_SPAN) span_q[idx - CFG_FRONT_STOP_SPAN] = SPAN_W'(value);
    else limit_q[idx - CFG_FRONT_STOP_LIMIT] = LIMIT_W'(value);
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_loaded++;
    @(negedge clk);
  endtask

  task automatic random_config();
    for (int k = 0; k < SECTORS; k++) begin
      write_reg(cfg_idx_t'(CFG_FRONT_STOP_SPAN + k), pick_span());
      write_reg(cfg_idx_t'(CFG_FRONT_STOP_LIMIT + k), pick_limit());
    end
    end_writes();
  endtask

  // wait until the block is idle with every result checked
  task automatic settle();
    @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_flags.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one scan: mostly head, a window near a sector start and tail; else noise
  task automatic queue_scan();
    int idx_list [$];
    int head_n;
    int tail_n;
    int mid_n;
    int mid_at;
    bit hot;
    int n;
    hot = $urandom_range(0, 1);
    if ($urandom_range(0, 9) < 2) begin
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++)
        add_sample(pick_range($urandom_range(0, 1)), $urandom_range(0, 511),
                   (i == n - 1) ? $urandom_range(0, 1) : ($urandom_range(0, 9) == 0));
      return;
    end
    if ($urandom_range(0, 29) == 0) begin
      for (int i = 0; i < SCAN_POINTS; i++) idx_list.insert(idx_list.size(), i);
    end else begin
      head_n = $urandom_range(0, 10);
      tail_n = $urandom_range(1, 10);
      mid_n = $urandom_range(0, 12);
      mid_at = span_q[$urandom_range(0, SECTORS - 1)][SPAN_W-1:IDX_W];
      mid_at = mid_at - $urandom_range(0, 3);
      if (mid_at < head_n) mid_at = head_n;
      if (mid_at + mid_n > SCAN_POINTS - tail_n) mid_n = SCAN_POINTS - tail_n - mid_at;
      if (mid_n < 0) mid_n = 0;
      for (int i = 0; i < head_n; i++) idx_list.insert(idx_list.size(), i);
      for (int i = 0; i < mid_n; i++) idx_list.insert(idx_list.size(), mid_at + i);
      for (int i = SCAN_POINTS - tail_n; i < SCAN_POINTS; i++)
        idx_list.insert(idx_list.size(), i);
    end
    foreach (idx_list[i]) begin
      if ($urandom_range(0, 5) == 0) hot = !hot;
      add_sample(pick_range(hot), idx_list[i], i == idx_list.size() - 1);
    end
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        fold_sample(in_data);
        samples_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_data <= pending_samples.pop_front();
          in_valid <= 1'b1;
          send_gap <= idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic compare_flag(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s expected %0b got %0b", name, want, got);
      failures++;
    end
  endtask

  task automatic check_flags(input out_t got);
    out_t want;
    if (expected_flags.size() == 0) begin
      $error("result beat %b with no scan closed", got);
      failures++;
      return;
    end
    want = expected_flags.pop_front();
    compare_flag("front_stop_clear", want.front_stop_clear, got.front_stop_clear);
    compare_flag("rear_stop_clear", want.rear_stop_clear, got.rear_stop_clear);
    compare_flag("front_slow_clear", want.front_slow_clear, got.front_slow_clear);
    compare_flag("rear_slow_clear", want.rear_slow_clear, got.rear_slow_clear);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        check_flags(out_data);
        results_seen++;
      end
      if (hold_asked != hold_granted) begin
        // long hold so the block backs up into its input
        hold_granted <= hold_asked;
        stall_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left <= idle_len();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    for (int k = 0; k < SECTORS; k++) begin
      span_q[k] = SPAN_RESET[k];
      limit_q[k] = LIMIT_RESET[k];
    end
    clear_tracks();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: wrap join, index past the scan, runs at the limit
    add_sample(150, 0, 0);
    add_sample(149, 1, 0);
    add_sample(65535, 180, 0);
    add_sample(0, 357, 0);
    add_sample(1, 358, 0);
    add_sample(2, 359, 1);
    for (int i = 170; i < 174; i++) add_sample(200, i, 0);
    add_sample(0, 360, 0);
    add_sample(200, 174, 0);
    add_sample(0, 511, 1);
    add_sample(201, 180, 0);
    for (int i = 181; i < 186; i++) add_sample(200, i, i == 185);
    add_sample(65535, 0, 1);
    settle();

    // empty, single-index and near-full sectors, limits at both ends
    write_reg(CFG_FRONT_STOP_SPAN, 0);
    write_reg(CFG_REAR_STOP_SPAN, 184167);
    write_reg(CFG_FRONT_SLOW_SPAN, (SCAN_POINTS - 1) * 512);
    write_reg(CFG_REAR_SLOW_SPAN, SCAN_POINTS - 1);
    write_reg(CFG_FRONT_STOP_LIMIT, 0);
    write_reg(CFG_REAR_STOP_LIMIT, 65535);
    write_reg(CFG_FRONT_SLOW_LIMIT, 65535);
    write_reg(CFG_REAR_SLOW_LIMIT, 0);
    end_writes();
    idle_on = 1'b1;
    repeat (4) queue_scan();
    settle();

    // every index covered, every range a hit
    for (int k = 0; k < SECTORS; k++) begin
      write_reg(cfg_idx_t'(CFG_FRONT_STOP_SPAN + k), 511);
      write_reg(cfg_idx_t'(CFG_FRONT_STOP_LIMIT + k), 65535);
    end
    end_writes();
    repeat (4) queue_scan();
    settle();

    // back-pressure: short scans while results are held off
    random_config();
    idle_on = 1'b0;
    hold_asked++;
    for (int s = 0; s < 30; s++) begin
      int n;
      int at;
      n = $urandom_range(1, 4);
      at = $urandom_range(0, SCAN_POINTS - 5);
      for (int i = 0; i < n; i++) add_sample(pick_range($urandom_range(0, 1)), at + i, i == n - 1);
    end
    settle();

    // random settings and scans
    while (samples_queued < ITEM_GOAL) begin
      random_config();
      idle_on = ($urandom_range(0, 9) < 7);
      repeat ($urandom_range(5, 12)) queue_scan();
      settle();
    end

    $display("covered %0d samples and %0d closed scans over %0d register settings,",
             samples_taken, results_seen, settings_loaded);
    $display("with random gaps on both sides and a %0d-cycle output hold", LONG_HOLD);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/sord_pkg.sv
rtl/sord_front.sv
rtl/sord_queue.sv
rtl/sord_back.sv
rtl/sector_obstacle_run_detector.sv
tb/sv/testbench.sv
